// ===== rtl/sig_pkg.sv =====
// ----------------------------------------------------------------------------
// sig_pkg
// Shared types and constants of the shuffled id generator: field widths,
// command and status codes, transfer payloads and the memory request.
// ----------------------------------------------------------------------------
package sig_pkg;

  localparam int ID_BITS       = 16;
  localparam int DISTANCE_BITS = 15;
  localparam int TABLE_SIZE    = 1 << ID_BITS;

  localparam logic [1:0] CMD_RESTART  = 2'd0;
  localparam logic [1:0] CMD_FILL     = 2'd1;
  localparam logic [1:0] CMD_GENERATE = 2'd2;

  localparam logic [1:0] STAT_VALID     = 2'd0;
  localparam logic [1:0] STAT_FILLED    = 2'd1;
  localparam logic [1:0] STAT_NOT_READY = 2'd2;
  localparam logic [1:0] STAT_BAD_PICK  = 2'd3;

  localparam logic [ID_BITS:0] FILL_LAST = {1'b0, {ID_BITS{1'b1}}};

  typedef struct packed {
    logic [1:0]               command;
    logic [ID_BITS-1:0]       fill_pick;
    logic [DISTANCE_BITS-1:0] swap_distance;
  } sig_in_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id_value;
    logic [1:0]         status;
  } sig_out_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } sig_state_t;

  typedef enum logic [1:0] {
    OP_FILL,
    OP_GEN,
    OP_REPORT
  } sig_op_t;

  typedef struct packed {
    logic               rd_en;
    logic               we_a;
    logic               we_b;
    logic [ID_BITS-1:0] addr_a;
    logic [ID_BITS-1:0] addr_b;
    logic [ID_BITS-1:0] wdata_a;
    logic [ID_BITS-1:0] wdata_b;
  } sig_mem_req_t;

endpackage

// ===== rtl/sig_perm_mem.sv =====
// ----------------------------------------------------------------------------
// sig_perm_mem
// Permutation table: dual-port synchronous memory, one read or write per
// port per cycle, registered read data.
// ----------------------------------------------------------------------------
module sig_perm_mem (
  input  logic                          clk,
  input  sig_pkg::sig_mem_req_t         req,
  output logic [sig_pkg::ID_BITS-1:0]   rd_a,
  output logic [sig_pkg::ID_BITS-1:0]   rd_b
);
  import sig_pkg::*;

  logic [ID_BITS-1:0] mem [TABLE_SIZE];
  logic [ID_BITS-1:0] rd_a_r;
  logic [ID_BITS-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we_a) begin
      mem[req.addr_a] <= req.wdata_a;
    end
    if (req.we_b) begin
      mem[req.addr_b] <= req.wdata_b;
    end
    if (req.rd_en) begin
      rd_a_r <= mem[req.addr_a];
      rd_b_r <= mem[req.addr_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

// ===== rtl/sig_ctrl.sv =====
// ----------------------------------------------------------------------------
// sig_ctrl
// Command sequencer: decodes a transfer, reads the table in the accept
// cycle, then writes back and updates fill count, read index and ready flag
// in the exec state once the output is not blocked; restart clears them.
// ----------------------------------------------------------------------------
module sig_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  sig_pkg::sig_in_t      in_data,
  output logic                  in_stall,
  input  logic                  out_busy,
  output logic                  res_valid,
  output sig_pkg::sig_out_t     res_data,
  output sig_pkg::sig_mem_req_t mem_req,
  input  logic [sig_pkg::ID_BITS-1:0] rd_a,
  input  logic [sig_pkg::ID_BITS-1:0] rd_b
);
  import sig_pkg::*;

  sig_state_t          state_r, state_nxt;
  sig_op_t             op_r, op_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [ID_BITS-1:0]  addr_a_r, addr_a_nxt;
  logic [ID_BITS-1:0]  addr_b_r, addr_b_nxt;
  logic [ID_BITS-1:0]  read_index_r, read_index_nxt;
  logic [ID_BITS:0]    fill_count_r, fill_count_nxt;
  logic                ready_r, ready_nxt;

  logic                accept;
  logic                go_exec;
  logic                res_needed;
  logic                blocked;
  logic [ID_BITS-1:0]  fill_addr;
  logic [ID_BITS-1:0]  there;

  assign accept    = in_valid && !in_stall;
  assign fill_addr = fill_count_r[ID_BITS-1:0];
  assign there     = read_index_r - ID_BITS'(in_data.swap_distance);

  always_comb begin
    case (op_r)
      OP_REPORT: res_needed = 1'b1;
      OP_FILL:   res_needed = (fill_count_r == FILL_LAST);
      OP_GEN:    res_needed = (rd_a != '0);
      default:   res_needed = 1'b0;
    endcase
  end

  assign blocked = res_needed && out_busy;
  assign go_exec = accept && (in_data.command == CMD_FILL || in_data.command == CMD_GENERATE)
                   && !(in_data.command == CMD_FILL && (ready_r || fill_count_r[ID_BITS]));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (go_exec) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!blocked) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall       = 1'b1;
    res_valid      = 1'b0;
    res_data       = '0;
    mem_req        = '0;
    op_nxt         = op_r;
    status_nxt     = status_r;
    addr_a_nxt     = addr_a_r;
    addr_b_nxt     = addr_b_r;
    read_index_nxt = read_index_r;
    fill_count_nxt = fill_count_r;
    ready_nxt      = ready_r;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_data.command)
            CMD_RESTART: begin
              read_index_nxt = '0;
              fill_count_nxt = '0;
              ready_nxt      = 1'b0;
            end
            CMD_FILL: begin
              if ({1'b0, in_data.fill_pick} > fill_count_r) begin
                op_nxt     = OP_REPORT;
                status_nxt = STAT_BAD_PICK;
              end else begin
                op_nxt         = OP_FILL;
                mem_req.rd_en  = 1'b1;
                mem_req.addr_a = in_data.fill_pick;
                mem_req.addr_b = in_data.fill_pick;
              end
              addr_a_nxt = in_data.fill_pick;
            end
            CMD_GENERATE: begin
              if (!ready_r) begin
                op_nxt     = OP_REPORT;
                status_nxt = STAT_NOT_READY;
              end else begin
                op_nxt         = OP_GEN;
                mem_req.rd_en  = 1'b1;
                mem_req.addr_a = read_index_r;
                mem_req.addr_b = there;
              end
              addr_a_nxt = read_index_r;
              addr_b_nxt = there;
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        case (op_r)
          OP_FILL: begin
            mem_req.addr_a  = fill_addr;
            mem_req.wdata_a = rd_a;
            mem_req.addr_b  = addr_a_r;
            mem_req.wdata_b = fill_addr;
            if (!blocked) begin
              // same slot: the second write wins
              mem_req.we_a   = (addr_a_r != fill_addr);
              mem_req.we_b   = 1'b1;
              fill_count_nxt = fill_count_r + 1'b1;
              if (fill_count_r == FILL_LAST) begin
                ready_nxt = 1'b1;
              end
            end
            res_data.status = STAT_FILLED;
          end
          OP_GEN: begin
            mem_req.addr_a  = addr_a_r;
            mem_req.wdata_a = rd_b;
            mem_req.addr_b  = addr_b_r;
            mem_req.wdata_b = rd_a;
            if (!blocked) begin
              mem_req.we_a   = 1'b1;
              mem_req.we_b   = 1'b1;
              read_index_nxt = read_index_r + 1'b1;
            end
            res_data.id_value = rd_a;
            res_data.status   = STAT_VALID;
          end
          default: begin
            res_data.status = status_r;
          end
        endcase
        res_valid = res_needed && !blocked;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      read_index_r <= '0;
      fill_count_r <= '0;
      ready_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_index_r <= read_index_nxt;
      fill_count_r <= fill_count_nxt;
      ready_r      <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    status_r <= status_nxt;
    addr_a_r <= addr_a_nxt;
    addr_b_r <= addr_b_nxt;
  end

endmodule

// ===== rtl/shuffled_id_generator.sv =====
// ----------------------------------------------------------------------------
// shuffled_id_generator
// Hands out 16-bit identifiers from a shuffled permutation table.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with in_data (command, fill_pick,
//   swap_distance). restart clears fill count, read index and ready flag.
//   2^16 fill steps, each with a position not above the fill count, build
//   the table; the last one returns status filled. generate then returns
//   a nonzero id with status valid, or nothing when the drawn entry is zero.
//   errors (bad pick, generate before ready) return a status with id 0.
//   output channel: out_valid / out_stall with out_data (id_value, status),
//   held in an output register until the transfer completes.
//   sequence: a valid fill or generate reads the table in the accept cycle,
//   then writes back on both ports of the dual-port table in the exec state
//   (one port for a self-swap fill); restart and ignored commands stay idle.
//   a new item is still taken while the output register is full and stalled;
//   if it returns a result, its write-back waits until the register frees up.
//   reset clears control state only; table contents are kept and are
//   undefined until filled.
// ----------------------------------------------------------------------------
module shuffled_id_generator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  sig_pkg::sig_in_t  in_data,
  output logic              in_stall,
  output logic              out_valid,
  output sig_pkg::sig_out_t out_data,
  input  logic              out_stall
);
  import sig_pkg::*;

  sig_mem_req_t       mem_req;
  logic [ID_BITS-1:0] rd_a;
  logic [ID_BITS-1:0] rd_b;
  logic               res_valid;
  sig_out_t           res_data;
  logic               out_busy;
  logic               out_valid_r;
  sig_out_t           out_data_r;

  assign out_busy = out_valid_r && out_stall;

  sig_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_busy  (out_busy),
    .res_valid (res_valid),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  sig_perm_mem u_mem (
    .clk  (clk),
    .req  (mem_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
